@@ hdl/tfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants for the telemetry frame deframer: frame header
// bytes, function codes, result status codes and the close-out sequencer states.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int DEFAULT_BUFFER_BYTES = 64;

	localparam logic [7:0] HDR_BYTE0      = 8'hAA;
	localparam logic [7:0] HDR_BYTE1      = 8'hAF;
	localparam logic [7:0] LEN_OVERHEAD   = 8'd5;
	localparam logic [7:0] FN_PID_FIRST   = 8'h10;
	localparam logic [7:0] FN_PID_LAST    = 8'h15;
	localparam logic [7:0] FN_READ        = 8'h02;
	localparam logic [7:0] RD_CODE_PID    = 8'h01;
	localparam logic [7:0] RD_CODE_VER    = 8'hA0;
	localparam logic [7:0] PID_GROUP_BASE = 8'h0F;

	localparam int GAIN_COUNT    = 9;
	localparam int GAIN_BASE     = 4;
	localparam int MIN_PID_BYTES = 22;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_BAD_HEADER = 3'd1,
		STAT_BAD_LENGTH = 3'd2,
		STAT_BAD_SUM    = 3'd3,
		STAT_OVERFLOW   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_HDR0,
		SEQ_HDR1,
		SEQ_LEN,
		SEQ_FUNC,
		SEQ_SUB,
		SEQ_GAIN_HI,
		SEQ_GAIN_LO
	} seq_state_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         function_word;
		logic [7:0]         sub_command;
		logic               request_pid;
		logic               request_version;
		logic [2:0]         pid_group;
		logic               ack_valid;
		logic [7:0]         ack_sum;
		logic [3:0]         gain_index;
		logic signed [15:0] gain_value;
		logic               last;
	} result_t;

endpackage

@@ hdl/tfd_frame_buf.sv @@
// ----------------------------------------------------------------------------
// tfd_frame_buf
// Frame byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tfd_frame_buf
	import tfd_pkg::*;
#(
	parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES,
	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [BUFFER_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

@@ hdl/telemetry_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Collects received bytes into a frame buffer, checks header, length and
// additive checksum on line idle, and decodes the function word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one beat per received event: s_tuser 0 = data byte in
//   s_tdata[7:0], s_tuser 1 = line idle, which closes the frame.
//   m_* carries results; m_tlast marks the final result of a frame.
//   A data byte gives no result; bytes may stream back to back. On line
//   idle a sequencer walks the frame buffer through its one read port, one
//   byte per cycle while the output is not stalled: a failed check gives its
//   result at the step that finds it, a good frame after the function and
//   sub-command bytes are read. A good PID write gives nine gain results
//   instead, each after two reads (one read for each gain byte).
//   s_tready is low while the sequencer runs.
//   A single output register holds the result; while the receiver stalls the
//   sequencer waits before each result with s_tready held low. Once the last
//   result of a frame is in the register, bytes of the next frame are taken.
//   Reset empties the frame (count, sum, overflow) and the output register;
//   buffer contents are not cleared, only bytes of the current frame are read.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer
	import tfd_pkg::*;
#(
	parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] status, [10:3] function_word, [18:11] sub_command, [19] request_pid,
	// [20] request_version, [23:21] pid_group, [24] ack_valid, [32:25] ack_sum,
	// [36:33] gain_index, [52:37] gain_value, [55:53] zero
	output logic [55:0] m_tdata,
	output logic        m_tlast
);

	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int LW = (CW > 9) ? CW : 9;

	seq_state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [7:0]    sum_q;
	logic [7:0]    prev_q;
	logic          ovf_q;
	logic [3:0]    gidx_q;
	logic [7:0]    fw_q;
	logic [7:0]    sc_q;
	logic [7:0]    hi_q;
	logic          m_tvalid_q;
	result_t       out_q;

	logic          in_fire;
	logic          byte_fire;
	logic          close_fire;
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          out_free;
	logic          emit;
	logic          fire;
	logic          adv;
	result_t       res;
	logic [7:0]    ck_sum;
	logic [LW-1:0] len_want;
	logic [LW-1:0] cnt_ext;
	logic          fn_is_pid;
	logic          gain_last;
	logic [4:0]    ghi_addr;
	logic [4:0]    glo_addr;
	logic [4:0]    gnext_addr;

	assign s_tready   = (state_q == SEQ_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign byte_fire  = in_fire && !s_tuser;
	assign close_fire = in_fire && s_tuser;
	assign wr_en      = byte_fire && (count_q < CW'(BUFFER_BYTES));

	assign out_free   = !m_tvalid_q || m_tready;
	assign fire       = emit && out_free;
	assign adv        = !emit || fire;

	assign ck_sum     = sum_q - prev_q;
	assign len_want   = LW'(rd_data) + LW'(LEN_OVERHEAD);
	assign cnt_ext    = LW'(count_q);
	assign fn_is_pid  = (fw_q >= FN_PID_FIRST) && (fw_q <= FN_PID_LAST);
	assign gain_last  = (gidx_q == 4'(GAIN_COUNT - 1));
	assign ghi_addr   = 5'(GAIN_BASE) + {gidx_q, 1'b0};
	assign glo_addr   = ghi_addr + 5'd1;
	assign gnext_addr = ghi_addr + 5'd2;

	tfd_frame_buf #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(s_tdata),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// result, emit request and buffer read address per sequencer step;
	// rd_data always holds the byte addressed in the previous cycle
	always_comb begin
		res     = '0;
		emit    = 1'b0;
		rd_addr = '0;
		case (state_q)
			SEQ_IDLE: begin
				rd_addr = '0;
			end
			SEQ_HDR0: begin
				res.last = 1'b1;
				if (ovf_q) begin
					emit       = 1'b1;
					res.status = STAT_OVERFLOW;
				end else if (count_q < CW'(2) || rd_data != HDR_BYTE0) begin
					emit       = 1'b1;
					res.status = STAT_BAD_HEADER;
				end
				rd_addr = adv ? AW'(1) : AW'(0);
			end
			SEQ_HDR1: begin
				res.last = 1'b1;
				if (rd_data != HDR_BYTE1) begin
					emit       = 1'b1;
					res.status = STAT_BAD_HEADER;
				end else if (count_q < CW'(4)) begin
					emit       = 1'b1;
					res.status = STAT_BAD_LENGTH;
				end
				rd_addr = adv ? AW'(3) : AW'(1);
			end
			SEQ_LEN: begin
				res.last = 1'b1;
				if (len_want != cnt_ext) begin
					emit       = 1'b1;
					res.status = STAT_BAD_LENGTH;
				end else if (ck_sum != prev_q) begin
					emit       = 1'b1;
					res.status = STAT_BAD_SUM;
				end
				rd_addr = adv ? AW'(2) : AW'(3);
			end
			SEQ_FUNC: begin
				rd_addr = AW'(4);
			end
			SEQ_SUB: begin
				res.last          = 1'b1;
				res.function_word = fw_q;
				res.sub_command   = rd_data;
				if (fn_is_pid) begin
					// short pid frame: gain bytes never arrived
					if (count_q < CW'(MIN_PID_BYTES)) begin
						emit       = 1'b1;
						res.status = STAT_OVERFLOW;
					end
				end else begin
					emit = 1'b1;
					if (fw_q == FN_READ) begin
						res.request_pid     = (rd_data == RD_CODE_PID);
						res.request_version = (rd_data == RD_CODE_VER);
					end
				end
				rd_addr = AW'(GAIN_BASE);
			end
			SEQ_GAIN_HI: begin
				rd_addr = AW'(glo_addr);
			end
			SEQ_GAIN_LO: begin
				emit              = 1'b1;
				res.status        = STAT_OK;
				res.function_word = fw_q;
				res.sub_command   = sc_q;
				res.pid_group     = 3'(fw_q - PID_GROUP_BASE);
				res.ack_valid     = 1'b1;
				res.ack_sum       = ck_sum;
				res.gain_index    = gidx_q;
				res.gain_value    = {hi_q, rd_data};
				res.last          = gain_last;
				rd_addr           = adv ? AW'(gnext_addr) : AW'(glo_addr);
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (close_fire) begin
					state_d = SEQ_HDR0;
				end
			end
			SEQ_HDR0: begin
				if (!emit) begin
					state_d = SEQ_HDR1;
				end else if (fire) begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_HDR1: begin
				if (!emit) begin
					state_d = SEQ_LEN;
				end else if (fire) begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_LEN: begin
				if (!emit) begin
					state_d = SEQ_FUNC;
				end else if (fire) begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_FUNC: begin
				state_d = SEQ_SUB;
			end
			SEQ_SUB: begin
				if (!emit) begin
					state_d = SEQ_GAIN_HI;
				end else if (fire) begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_GAIN_HI: begin
				state_d = SEQ_GAIN_LO;
			end
			SEQ_GAIN_LO: begin
				if (fire) begin
					state_d = gain_last ? SEQ_IDLE : SEQ_GAIN_HI;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			count_q    <= '0;
			sum_q      <= '0;
			prev_q     <= '0;
			ovf_q      <= 1'b0;
			gidx_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + s_tdata;
				prev_q  <= s_tdata;
			end else if (byte_fire) begin
				ovf_q <= 1'b1;
			end
			// frame closed out: start the next one empty
			if (fire && res.last) begin
				count_q <= '0;
				sum_q   <= '0;
				prev_q  <= '0;
				ovf_q   <= 1'b0;
			end
			if (state_q == SEQ_SUB) begin
				gidx_q <= '0;
			end else if (state_q == SEQ_GAIN_LO && fire) begin
				gidx_q <= gidx_q + 4'd1;
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_FUNC) begin
			fw_q <= rd_data;
		end
		if (state_q == SEQ_SUB) begin
			sc_q <= rd_data;
		end
		if (state_q == SEQ_GAIN_HI) begin
			hi_q <= rd_data;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {3'b000, out_q.gain_value, out_q.gain_index, out_q.ack_sum,
		out_q.ack_valid, out_q.pid_group, out_q.request_version, out_q.request_pid,
		out_q.sub_command, out_q.function_word, out_q.status};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUFFER_BYTES))
		else $error("frame byte count beyond buffer size");

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.last |=> count_q == '0 && !ovf_q)
		else $error("frame state not cleared after close");

	a_mid_is_gain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> out_q.ack_valid && out_q.status == STAT_OK)
		else $error("non-final result that is not a gain beat");

	a_gain_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_GAIN_LO && !out_free |=> state_q == SEQ_GAIN_LO
		&& $stable(gidx_q))
		else $error("gain sequencer moved while output stalled");
`endif

endmodule
